### rtl/crcpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcpd_pkg
// Shared constants, types and the CRC-16/ARC byte step for the deframer.
// ----------------------------------------------------------------------------
package crcpd_pkg;

    // Largest payload the window is sized for, and the window depth
    localparam int MAX_PAYLOAD = 48;
    localparam int WIN_DEPTH   = MAX_PAYLOAD + 7;

    // Reflected CRC-16/ARC polynomial
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration register indexes
    localparam logic [7:0] REG_SYNC    = 8'd0;
    localparam logic [7:0] REG_VERSION = 8'd1;
    localparam logic [7:0] REG_CRASH   = 8'd2;
    localparam logic [7:0] REG_MAXLEN  = 8'd3;

    // Frame byte offsets within the window
    localparam logic [5:0] OFS_SYNC    = 6'd0;
    localparam logic [5:0] OFS_VERSION = 6'd1;
    localparam logic [5:0] OFS_FLAGS   = 6'd2;
    localparam logic [5:0] OFS_LEN_L   = 6'd3;
    localparam logic [5:0] OFS_LEN_H   = 6'd4;
    localparam logic [5:0] OFS_NODE    = 6'd7;
    localparam logic [5:0] OFS_FUNC    = 6'd8;
    localparam logic [5:0] OFS_ERR_L   = 6'd9;
    localparam logic [5:0] OFS_ERR_H   = 6'd10;
    localparam logic [5:0] OFS_DATA    = 6'd11;

    // Cell operations
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_LOAD  = 2'd1;
    localparam logic [1:0] CELL_SHIFT = 2'd2;
    localparam logic [1:0] CELL_ROT   = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] fill;
        logic [7:0] din;
    } t_cell_ctl;

    // One byte of CRC-16/ARC: xor in, then eight reflected shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/crcpd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcpd_cell
// One window byte: loads a new byte, shifts toward the head, or rotates the
// head byte back in at the tail of the filled part.
// ----------------------------------------------------------------------------
module crcpd_cell
    import crcpd_pkg::*;
(
    input  logic       i_clk,
    input  logic [5:0] i_pos,
    input  t_cell_ctl  i_ctl,
    input  logic [7:0] i_next,
    input  logic [7:0] i_head,
    output logic [7:0] o_q
);

    logic [7:0] r_q;
    logic [7:0] n_q;

    // Pick the next byte for this position
    always_comb begin
        n_q = r_q;
        case (i_ctl.op)
            CELL_LOAD: begin
                if (i_pos == i_ctl.fill) n_q = i_ctl.din;
            end
            CELL_SHIFT: n_q = i_next;
            CELL_ROT: begin
                if (i_pos == i_ctl.fill - 6'd1) n_q = i_head;
                else n_q = i_next;
            end
            default: n_q = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

### rtl/crc16_packet_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_packet_deframer_unit
// Sync / version / length / payload / CRC-16 deframer built on a row of
// byte cells that rotate the receive window past one checking head.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  in       | i_in_valid / o_in_stall  | i_rx_byte
//  out      | o_out_valid / i_out_stall| node_id, fn_code, error_word,
//           |                          | crash_hit, data_byte, has_data, last
//  cfg      | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// A scan pass rotates the filled window once through the cells, followed by a
// decide step. A failed pass drops one byte and rescans, so one item can take
// up to about 55 passes. A good frame shifts out one byte a cycle, pausing
// while the output register is full. Input is stalled until the window is idle
// again. Reset empties the window; no clearing pass.
// ----------------------------------------------------------------------------
module crc16_packet_deframer_unit
    import crcpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_node_id,
    output logic [7:0]  o_fn_code,
    output logic [15:0] o_error_word,
    output logic        o_crash_hit,
    output logic [7:0]  o_data_byte,
    output logic        o_has_data,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_DROP   = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    localparam logic [5:0] DEPTH = 6'(WIN_DEPTH);
    localparam logic [5:0] LIMIT = 6'(MAX_PAYLOAD);

    logic [7:0]  r_sync, r_version, r_crash_mask;
    logic [5:0]  r_max_len;
    logic [2:0]  r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [5:0]  r_idx, n_idx;
    logic [15:0] r_crc, n_crc;
    logic        r_fail, n_fail;
    logic [7:0]  r_len_lo;
    logic [5:0]  r_len;
    logic [7:0]  r_node, r_func, r_flags;
    logic [15:0] r_err;
    logic        r_out_valid;
    logic [7:0]  r_out_data;
    logic        r_out_has, r_out_last, r_out_crash;
    logic [7:0]  r_out_node, r_out_func;
    logic [15:0] r_out_err;

    t_cell_ctl   w_ctl;
    logic [7:0]  w_q [0:WIN_DEPTH];
    logic [7:0]  w_head;
    logic [5:0]  w_limit;
    logic [15:0] w_len16;
    logic        w_len_bad;
    logic [6:0]  w_idx7, w_len7;
    logic        w_crc_due;
    logic        w_fail_now;
    logic        w_in_acc;
    logic        w_slot_free;
    logic        w_emit_here, w_emit_last, w_shift_ok;

    assign w_head   = w_q[0];
    assign w_q[WIN_DEPTH] = 8'h00;
    assign w_in_acc = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Row of window cells
    for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
        crcpd_cell u_cell (
            .i_clk  (i_clk),
            .i_pos  (6'(k)),
            .i_ctl  (w_ctl),
            .i_next (w_q[k + 1]),
            .i_head (w_head),
            .o_q    (w_q[k])
        );
    end

    // Header checks on the byte at the head
    assign w_limit   = (r_max_len < LIMIT) ? r_max_len : LIMIT;
    assign w_len16   = {w_head, r_len_lo};
    assign w_len_bad = (w_len16 == 16'd0) || (w_len16 > {10'd0, w_limit});
    assign w_idx7    = {1'b0, r_idx};
    assign w_len7    = {1'b0, r_len};
    // CRC bytes count only once the whole frame is in the window
    assign w_crc_due = ({1'b0, r_fill} >= w_len7 + 7'd7);

    always_comb begin
        w_fail_now = 1'b0;
        if (r_idx == OFS_SYNC && w_head != r_sync) w_fail_now = 1'b1;
        if (r_idx == OFS_VERSION && w_head != r_version) w_fail_now = 1'b1;
        if (r_idx == OFS_LEN_H && w_len_bad) w_fail_now = 1'b1;
        if (r_idx > OFS_LEN_H && w_crc_due && w_idx7 == w_len7 + 7'd5 &&
            w_head != r_crc[7:0])
            w_fail_now = 1'b1;
        if (r_idx > OFS_LEN_H && w_crc_due && w_idx7 == w_len7 + 7'd6 &&
            w_head != r_crc[15:8])
            w_fail_now = 1'b1;
    end

    // Result slots while a good frame shifts out
    assign w_slot_free = !r_out_valid || !i_out_stall;
    always_comb begin
        if (r_len > 6'd6) begin
            w_emit_here = (r_idx >= OFS_DATA) && (w_idx7 < w_len7 + 7'd5);
            w_emit_last = (w_idx7 == w_len7 + 7'd4);
        end else begin
            w_emit_here = (r_idx == OFS_ERR_H);
            w_emit_last = 1'b1;
        end
    end
    assign w_shift_ok = !w_emit_here || w_slot_free;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_crc     = r_crc;
        n_fail    = r_fail;
        w_ctl.op   = CELL_HOLD;
        w_ctl.fill = r_fill;
        w_ctl.din  = i_rx_byte;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (r_fill < DEPTH) begin
                        w_ctl.op = CELL_LOAD;
                        n_fill   = r_fill + 6'd1;
                    end
                    n_state = ST_SCAN;
                    n_idx   = 6'd0;
                    n_crc   = 16'h0000;
                    n_fail  = 1'b0;
                end
            end
            ST_SCAN: begin
                if (r_fill == 6'd0) begin
                    n_state = ST_IDLE;
                end else begin
                    w_ctl.op = CELL_ROT;
                    n_idx    = r_idx + 6'd1;
                    n_fail   = r_fail || w_fail_now;
                    if (r_idx > OFS_LEN_H && w_idx7 < w_len7 + 7'd5)
                        n_crc = crc16_byte(r_crc, w_head);
                    if (r_idx == r_fill - 6'd1) n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (r_fail) begin
                    n_state = ST_DROP;
                end else if (r_fill > OFS_LEN_H && {1'b0, r_fill} >= w_len7 + 7'd7) begin
                    n_state = (r_len < 6'd6) ? ST_DROP : ST_EMIT;
                    n_idx   = 6'd0;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DROP: begin
                w_ctl.op = CELL_SHIFT;
                n_fill   = r_fill - 6'd1;
                n_state  = ST_SCAN;
                n_idx    = 6'd0;
                n_crc    = 16'h0000;
                n_fail   = 1'b0;
            end
            ST_EMIT: begin
                if (w_shift_ok) begin
                    w_ctl.op = CELL_SHIFT;
                    n_fill   = r_fill - 6'd1;
                    n_idx    = r_idx + 6'd1;
                    if (w_idx7 == w_len7 + 7'd6) begin
                        n_state = ST_SCAN;
                        n_idx   = 6'd0;
                        n_crc   = 16'h0000;
                        n_fail  = 1'b0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_fill       <= 6'd0;
            r_idx        <= 6'd0;
            r_crc        <= 16'h0000;
            r_fail       <= 1'b0;
            r_len        <= 6'd0;
            r_out_valid  <= 1'b0;
            r_sync       <= 8'h00;
            r_version    <= 8'h00;
            r_crash_mask <= 8'h00;
            r_max_len    <= 6'd48;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            r_crc   <= n_crc;
            r_fail  <= n_fail;
            if (r_state == ST_SCAN && r_fill != 6'd0 && r_idx == OFS_LEN_H && !w_len_bad)
                r_len <= w_len16[5:0];
            // hold result until taken, load on an emitted byte
            if (!i_out_stall) r_out_valid <= 1'b0;
            if (r_state == ST_EMIT && w_emit_here && w_slot_free) r_out_valid <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SYNC:    r_sync       <= i_cfg_data;
                    REG_VERSION: r_version    <= i_cfg_data;
                    REG_CRASH:   r_crash_mask <= i_cfg_data;
                    REG_MAXLEN:  r_max_len    <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

    // Capture header fields and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && r_fill != 6'd0) begin
            case (r_idx)
                OFS_FLAGS: r_flags       <= w_head;
                OFS_LEN_L: r_len_lo      <= w_head;
                OFS_NODE:  r_node        <= w_head;
                OFS_FUNC:  r_func        <= w_head;
                OFS_ERR_L: r_err[7:0]    <= w_head;
                OFS_ERR_H: r_err[15:8]   <= w_head;
                default: ;
            endcase
        end
        if (r_state == ST_EMIT && w_emit_here && w_slot_free) begin
            r_out_node  <= r_node;
            r_out_func  <= r_func;
            r_out_err   <= r_err;
            r_out_crash <= |(r_flags & r_crash_mask);
            r_out_has   <= (r_len > 6'd6);
            r_out_data  <= (r_len > 6'd6) ? w_head : 8'h00;
            r_out_last  <= w_emit_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_node_id    = r_out_node;
    assign o_fn_code    = r_out_func;
    assign o_error_word = r_out_err;
    assign o_crash_hit  = r_out_crash;
    assign o_data_byte  = r_out_data;
    assign o_has_data   = r_out_has;
    assign o_last       = r_out_last;

endmodule

### tb/sv/crc16_packet_deframer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_packet_deframer_unit_tb
// Self-checking bench for the packet deframer. Random and well-formed frames
// go in one byte per item; a frame predictor in a scoreboard class keeps its
// own window and produces the expected result items, which are compared field
// by field with what the block emits. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module crc16_packet_deframer_unit_tb
    import crcpd_pkg::*;
();

    typedef struct {
        logic [7:0]  node_id;
        logic [7:0]  fn_code;
        logic [15:0] error_word;
        logic        crash_hit;
        logic [7:0]  data_byte;
        logic        has_data;
        logic        last;
    } t_frame_result;

    // Frame predictor plus queue of expected result items
    class t_deframe_board;
        logic [7:0] sync_byte, version_byte, crash_bits;
        logic [5:0] max_len;
        logic [7:0] win[$];
        t_frame_result pending[$];
        int errors, results, frames;

        function new();
            sync_byte = 0; version_byte = 0; crash_bits = 0; max_len = 6'd48;
            errors = 0; results = 0; frames = 0;
        endfunction

        function void set_reg(logic [7:0] idx, logic [7:0] val);
            case (idx)
                REG_SYNC:    sync_byte = val;
                REG_VERSION: version_byte = val;
                REG_CRASH:   crash_bits = val;
                REG_MAXLEN:  max_len = val[5:0];
                default: ;
            endcase
        endfunction

        // Returns -1 incomplete, 0 failure, else total frame length
        function int scan();
            int n, lim, len;
            logic [15:0] crc, rx_crc;
            n = win.size();
            lim = (max_len < MAX_PAYLOAD) ? max_len : MAX_PAYLOAD;
            if (n < 1) return -1;
            if (win[0] != sync_byte) return 0;
            if (n < 2) return -1;
            if (win[1] != version_byte) return 0;
            if (n < 5) return -1;
            len = {win[4], win[3]};
            if (len == 0 || len > lim) return 0;
            if (n < len + 7) return -1;
            crc = 16'h0000;
            for (int i = 0; i < len; i++) begin
                crc = crc ^ {8'h00, win[5 + i]};
                for (int b = 0; b < 8; b++) begin
                    crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
                end
            end
            rx_crc = {win[6 + len], win[5 + len]};
            if (crc != rx_crc || len < 6) return 0;
            return len + 7;
        endfunction

        function void note_byte(logic [7:0] b);
            int r, nd, nr;
            t_frame_result e;
            if (win.size() < WIN_DEPTH) win.insert(win.size(), b);
            forever begin
                r = scan();
                if (r < 0) break;
                if (r == 0) begin
                    win.delete(0);
                    continue;
                end
                nd = r - 13;
                nr = nd ? nd : 1;
                frames++;
                for (int k = 0; k < nr; k++) begin
                    e.node_id = win[7];
                    e.fn_code = win[8];
                    e.error_word = {win[10], win[9]};
                    e.crash_hit = (win[2] & crash_bits) != 0;
                    e.data_byte = nd ? win[11 + k] : 8'h00;
                    e.has_data = nd != 0;
                    e.last = (k + 1 == nr);
                    pending.insert(pending.size(), e);
                end
                for (int k = 0; k < r; k++) win.delete(0);
            end
        endfunction

        function void check_result(t_frame_result a);
            t_frame_result e;
            results++;
            if (pending.size() == 0) begin
                $error("unexpected result item node_id=%h", a.node_id);
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (a.node_id !== e.node_id) begin
                $error("node_id exp %h got %h", e.node_id, a.node_id); errors++;
            end
            if (a.fn_code !== e.fn_code) begin
                $error("fn_code exp %h got %h", e.fn_code, a.fn_code); errors++;
            end
            if (a.error_word !== e.error_word) begin
                $error("error_word exp %h got %h", e.error_word, a.error_word); errors++;
            end
            if (a.crash_hit !== e.crash_hit) begin
                $error("crash_hit exp %b got %b", e.crash_hit, a.crash_hit); errors++;
            end
            if (a.data_byte !== e.data_byte) begin
                $error("data_byte exp %h got %h", e.data_byte, a.data_byte); errors++;
            end
            if (a.has_data !== e.has_data) begin
                $error("has_data exp %b got %b", e.has_data, a.has_data); errors++;
            end
            if (a.last !== e.last) begin
                $error("last exp %b got %b", e.last, a.last); errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_index = 8'h00;
    logic [7:0]  cfg_data = 8'h00;
    logic        in_stall, out_valid, cfg_ready;
    logic [7:0]  node_id, fn_code, data_byte;
    logic [15:0] error_word;
    logic        crash_hit, has_data, last;

    t_deframe_board board;
    logic [7:0]   stream[$];
    int           idle_cnt = 0;
    bit           quiet = 1'b0;
    bit           hold_long = 1'b0;

    always #4 clk = ~clk;

    crc16_packet_deframer_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_rx_byte(rx_byte),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_node_id(node_id), .o_fn_code(fn_code), .o_error_word(error_word),
        .o_crash_hit(crash_hit), .o_data_byte(data_byte), .o_has_data(has_data),
        .o_last(last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // Check each accepted result item and note progress for the watchdog
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            board.check_result('{node_id, fn_code, error_word, crash_hit,
                                 data_byte, has_data, last});
        end
        if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall) ||
                      (cfg_valid && cfg_ready)))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver stall: random bursts, one long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge clk);
            if (hold_long) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_long = 1'b0;
                out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 9);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_reg(idx, val);
        @(posedge clk);
    endtask

    // Send one byte item, with an optional idle gap beforehand
    task automatic send_byte(logic [7:0] b);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (in_stall);
        board.note_byte(b);
    endtask

    task automatic flush_stream();
        logic [7:0] b;
        while (stream.size() > 0) begin
            b = stream[0];
            stream.delete(0);
            send_byte(b);
        end
        in_valid <= 1'b0;
    endtask

    // Wait until every expected result has arrived and the block is idle
    task automatic drain();
        @(posedge clk);
        while (board.pending.size() > 0) @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic add_byte(logic [7:0] b);
        stream.insert(stream.size(), b);
    endtask

    // Queue one frame; kind 0 good, 1 bad crc, 2 bad version
    task automatic push_frame(int len, int kind);
        logic [7:0] pl[$];
        logic [15:0] crc;
        crc = 16'h0000;
        for (int i = 0; i < len; i++) pl.insert(pl.size(), 8'($urandom_range(0, 255)));
        foreach (pl[i]) begin
            crc = crc ^ {8'h00, pl[i]};
            for (int b = 0; b < 8; b++) crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
        end
        if (kind == 1) crc = ~crc;
        add_byte(board.sync_byte);
        add_byte(kind == 2 ? ~board.version_byte : board.version_byte);
        add_byte(8'($urandom_range(0, 255)));
        add_byte(len[7:0]);
        add_byte(len[15:8]);
        foreach (pl[i]) add_byte(pl[i]);
        add_byte(crc[7:0]);
        add_byte(crc[15:8]);
    endtask

    initial begin
        int r;
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, then extremes of the register settings and the length field
        push_frame(6, 0);
        flush_stream();
        drain();
        write_reg(REG_SYNC, 8'hFF);
        write_reg(REG_VERSION, 8'h00);
        write_reg(REG_CRASH, 8'hFF);
        write_reg(REG_MAXLEN, 8'd57);
        push_frame(48, 0);
        push_frame(5, 0);
        push_frame(6, 1);
        add_byte(8'hFF); add_byte(8'h00); add_byte(8'h00);
        add_byte(8'h00); add_byte(8'h00);
        push_frame(6, 0);
        flush_stream();
        drain();

        // Random phases through several register settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_SYNC, ph == 3 ? 8'h00 : 8'($urandom_range(0, 255)));
            write_reg(REG_VERSION, ph == 3 ? 8'hFF : 8'($urandom_range(0, 255)));
            write_reg(REG_CRASH, 8'($urandom_range(0, 255)));
            write_reg(REG_MAXLEN, ph == 2 ? 8'd0 :
                                  (ph == 1 ? 8'd1 : 8'($urandom_range(14, 63))));
            if (ph == 3) quiet = 1'b1;
            if (ph == 0) push_frame($urandom_range(10, 14), 0);
            else if (ph == 1) push_frame(6, 2);
            else push_frame($urandom_range(6, 10), 0);
            if (ph == 3) begin
                r = $urandom_range(0, 3);
                if (r == 0) push_frame($urandom_range(1, 12), 1);
                else if (r == 1) repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
                else push_frame($urandom_range(6, 14), 0);
            end
            if (ph == 0) hold_long = 1'b1;
            flush_stream();
            drain();
        end

        $display("covered %0d frames, %0d result items across reset, directed and",
                 board.frames, board.results);
        $display("four random register settings, with one long receiver hold-off");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
